// ----- rtl/core/chacha20_stream_cipher_macros.svh -----
// Assertion macros for the ChaCha20 stream cipher block
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Assert that a condition implies another in the same cycle
`define CC_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Assert that a condition implies another in the next cycle
`define CC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/cc20_pkg.sv -----
// Shared types, constants and functions for the ChaCha20 stream cipher
package cc20_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned NumRounds = 20;
  localparam int unsigned RoundCntW = 5;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CfgIdxW-1:0] RegKey0  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonce0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonce1 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd6;

  localparam logic [WordW-1:0] Sigma0 = 32'h61707865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h79622d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b206574;

  typedef struct packed {
    logic [31:0] data_in;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [2:0]  byte_count_out;
    logic        end_out;
  } out_req_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
    logic        new_block;
    logic        first;
    logic [3:0]  pos;
  } work_t;

  typedef logic [15:0][WordW-1:0] state_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  function automatic logic [127:0] qround(input logic [WordW-1:0] a, input logic [WordW-1:0] b,
                                          input logic [WordW-1:0] c, input logic [WordW-1:0] d);
    logic [WordW-1:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    return {a1, b1, c1, d1};
  endfunction

  function automatic state_t double_half(input state_t x, input logic diag);
    state_t y;
    logic [127:0] r;
    y = x;
    for (int i = 0; i < 4; i++) begin
      if (!diag) begin
        r = qround(x[i], x[4+i], x[8+i], x[12+i]);
        {y[i], y[4+i], y[8+i], y[12+i]} = r;
      end else begin
        r = qround(x[i], x[4+((i+1)%4)], x[8+((i+2)%4)], x[12+((i+3)%4)]);
        {y[i], y[4+((i+1)%4)], y[8+((i+2)%4)], y[12+((i+3)%4)]} = r;
      end
    end
    return y;
  endfunction

endpackage

// ----- rtl/core/cc20_front.sv -----
// Front end: classify each request by block position and message start and queue it
module cc20_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cc20_pkg::in_req_t in_req_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output cc20_pkg::work_t  q_work_o
);
  import cc20_pkg::*;

  work_t q_q [FifoDepth];
  logic  rd_q, wr_q;
  logic [1:0] cnt_q;
  logic [3:0] pos_q, pos_d;
  logic  inmsg_q, inmsg_d;
  logic  push, pop;
  work_t w;

  assign in_ready_o = (cnt_q != 2'(FifoDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_work_o   = q_q[rd_q];

  always_comb begin
    w.data      = in_req_i.data_in;
    w.count     = (in_req_i.byte_count > 3'd4) ? 3'd4 : in_req_i.byte_count;
    w.last      = in_req_i.end_of_message;
    w.first     = !inmsg_q;
    w.pos       = inmsg_q ? pos_q : 4'd0;
    w.new_block = (w.pos == 4'd0);
    pos_d       = in_req_i.end_of_message ? 4'd0 : w.pos + 4'd1;
    inmsg_d     = !in_req_i.end_of_message;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0; pos_q <= 4'd0; inmsg_q <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q; pos_q <= pos_d; inmsg_q <= inmsg_d;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- rtl/core/cc20_back.sv -----
// Back end: keystream block generator and XOR with output register
module cc20_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cc20_pkg::work_t   q_work_i,
  input  logic [255:0]      key_i,
  input  logic [95:0]       nonce_i,
  input  logic [31:0]       start_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cc20_pkg::out_req_t out_req_o,
  output logic              busy_o
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {StIdle = 2'b01, StRound = 2'b10} st_e;

  st_e st_q, st_d;
  state_t x_q, init_q, ks_q;
  logic [RoundCntW-1:0] rnd_q;
  logic [31:0] ctr_q;
  logic ov_q;
  logic ks_rdy_q;
  out_req_t o_q;
  state_t init_w;
  state_t x_nx;
  logic [31:0] ctr_use, mask, ksw;
  logic can_out, take, start_gen, last_rnd;

  assign can_out   = !ov_q || out_ready_i;
  assign ctr_use   = q_work_i.first ? start_i : ctr_q;
  assign last_rnd  = (st_q == StRound) && (rnd_q == RoundCntW'(NumRounds - 1));
  assign start_gen = (st_q == StIdle) && q_valid_i && q_work_i.new_block && !ks_rdy_q;
  assign take      = (st_q == StIdle) && q_valid_i && (!q_work_i.new_block || ks_rdy_q)
                     && can_out;
  assign q_ready_o = take;
  assign out_valid_o = ov_q;
  assign out_req_o = o_q;
  assign busy_o    = (st_q != StIdle);
  assign x_nx      = double_half(x_q, rnd_q[0]);

  always_comb begin
    init_w[0] = Sigma0; init_w[1] = Sigma1; init_w[2] = Sigma2; init_w[3] = Sigma3;
    for (int i = 0; i < 8; i++) init_w[4+i] = key_i[32*i +: 32];
    init_w[12] = ctr_use;
    for (int i = 0; i < 3; i++) init_w[13+i] = nonce_i[32*i +: 32];
  end

  always_comb begin
    case (q_work_i.count)
      3'd0: mask = 32'h0;
      3'd1: mask = 32'hff;
      3'd2: mask = 32'hffff;
      3'd3: mask = 32'hffffff;
      default: mask = 32'hffffffff;
    endcase
    ksw = ks_q[q_work_i.pos];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (start_gen) st_d = StRound;
      StRound: if (rnd_q == RoundCntW'(NumRounds - 1)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_gen) begin
      x_q <= init_w; init_q <= init_w;
    end else if (st_q == StRound) begin
      x_q <= x_nx;
      if (rnd_q == RoundCntW'(NumRounds - 1)) begin
        for (int i = 0; i < 16; i++) ks_q[i] <= x_nx[i] + init_q[i];
      end
    end
    if (take) begin
      o_q.data_out       <= (q_work_i.data ^ ksw) & mask;
      o_q.byte_count_out <= q_work_i.count;
      o_q.end_out        <= q_work_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; rnd_q <= '0; ctr_q <= '0; ov_q <= 1'b0; ks_rdy_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (start_gen) begin
        rnd_q <= '0; ctr_q <= ctr_use + 32'd1;
      end else if (st_q == StRound) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (last_rnd) ks_rdy_q <= 1'b1;
      else if (take) ks_rdy_q <= 1'b0;
      if (take) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule

// ----- rtl/core/chacha20_stream_cipher.sv -----
// Top level of the ChaCha20 stream cipher
//  channel | direction | handshake
//  in      | request in  | in_valid_i / in_ready_o
//  out     | request out | out_valid_o / out_ready_i
//  cfg     | write only  | cfg_we_i
// A word that opens a keystream block holds the round unit while it loads the state, runs
// twenty column or diagonal rounds at one per cycle and XORs; other words use the stored keystream.
// Reset clears control state and the key, nonce and start registers only.
// A two-entry queue parts the front end from the round unit; the output
// register holds its request while out_ready_i is low.
`include "chacha20_stream_cipher_macros.svh"
module chacha20_stream_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cc20_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cc20_pkg::out_req_t out_req_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  import cc20_pkg::*;

  logic [255:0] key_q;
  logic [95:0]  nonce_q;
  logic [31:0]  start_q;
  logic q_valid, q_ready, busy;
  work_t q_work;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0; nonce_q <= '0; start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0:   key_q[63:0]    <= cfg_data_i;
        RegKey1:   key_q[127:64]  <= cfg_data_i;
        RegKey2:   key_q[191:128] <= cfg_data_i;
        RegKey3:   key_q[255:192] <= cfg_data_i;
        RegNonce0: nonce_q[63:0]  <= cfg_data_i;
        RegNonce1: nonce_q[95:64] <= cfg_data_i[31:0];
        RegStart:  start_q        <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  cc20_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_work_o(q_work)
  );

  cc20_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_work_i(q_work),
    .key_i(key_q), .nonce_i(nonce_q), .start_i(start_q),
    .out_valid_o, .out_ready_i, .out_req_o, .busy_o(busy)
  );

  `CC_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, busy, !q_ready)
  `CC_ASSERT_NEXT(a_take_valid, clk_i, rst_ni, q_ready, out_valid_o)
  `CC_ASSERT_IMP(a_take_has_item, clk_i, rst_ni, q_ready, q_valid)
endmodule

// ----- bench/chacha20_stream_cipher_tb.sv -----
// Testbench for the ChaCha20 stream cipher: directed and random messages checked against a software keystream
`timescale 1ns / 100ps
module chacha20_stream_cipher_tb;
  import cc20_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;

  class cipher_scoreboard;
    logic [31:0] key_w[8];
    logic [31:0] nonce_w[3];
    logic [31:0] start_ctr;
    logic [31:0] ks[16];
    logic [3:0]  pos;
    logic [31:0] blk_ctr;
    bit          busy;
    out_req_t    pending[$];
    int          errors;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      foreach (nonce_w[i]) nonce_w[i] = '0;
      start_ctr = '0;
      pos = '0;
      blk_ctr = '0;
      busy = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        RegKey0, RegKey1, RegKey2, RegKey3: begin
          key_w[idx * 2] = val[31:0];
          key_w[idx * 2 + 1] = val[63:32];
        end
        RegNonce0: begin
          nonce_w[0] = val[31:0];
          nonce_w[1] = val[63:32];
        end
        RegNonce1: nonce_w[2] = val[31:0];
        RegStart: start_ctr = val[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rot(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(ref logic [31:0] x[16], input int a, int b, int c, int d);
      x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 16);
      x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 12);
      x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 8);
      x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 7);
    endfunction

    function void make_keystream();
      logic [31:0] init[16];
      logic [31:0] x[16];
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
      init[12] = blk_ctr;
      for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
      x = init;
      for (int r = 0; r < 10; r++) begin
        quarter(x, 0, 4, 8, 12);
        quarter(x, 1, 5, 9, 13);
        quarter(x, 2, 6, 10, 14);
        quarter(x, 3, 7, 11, 15);
        quarter(x, 0, 5, 10, 15);
        quarter(x, 1, 6, 11, 12);
        quarter(x, 2, 7, 8, 13);
        quarter(x, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = x[i] + init[i];
    endfunction

    function void note_request(in_req_t req);
      logic [2:0]  cnt;
      logic [31:0] mask;
      out_req_t    exp;
      cnt = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
      if (!busy) begin
        blk_ctr = start_ctr;
        pos = '0;
        busy = 1;
      end
      if (pos == 0) begin
        make_keystream();
        blk_ctr += 1;
      end
      mask = (cnt == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * cnt)) - 32'd1);
      exp.data_out = (req.data_in ^ ks[pos]) & mask;
      exp.byte_count_out = cnt;
      exp.end_out = req.end_of_message;
      pos += 1;
      if (req.end_of_message) begin
        busy = 0;
        pos = '0;
      end
      pending.push_back(exp);
    endfunction

    function void check_result(out_req_t act);
      out_req_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (act.data_out !== exp.data_out) begin
        $display("%0t: data_out expected %h actual %h", $time, exp.data_out, act.data_out);
        errors++;
      end
      if (act.byte_count_out !== exp.byte_count_out) begin
        $display("%0t: byte_count_out expected %0d actual %0d", $time,
                 exp.byte_count_out, act.byte_count_out);
        errors++;
      end
      if (act.end_out !== exp.end_out) begin
        $display("%0t: end_out expected %0d actual %0d", $time, exp.end_out, act.end_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_ready;
  out_req_t    out_req;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [63:0] cfg_data;
  bit          out_hold;

  cipher_scoreboard sb = new();

  chacha20_stream_cipher u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_req_o  (out_req),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_req);
  end

  initial begin
    int wait_cycles;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready || !out_ready) begin
        wait_cycles = out_hold ? 0 : $urandom_range(0, 5);
        if (wait_cycles > 0) begin
          out_ready <= 0;
          repeat (wait_cycles - 1) @(posedge clk);
          @(posedge clk);
        end
        out_ready <= 1;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic last, bit gaps);
    in_req_t req;
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.data_in = data;
    req.byte_count = cnt;
    req.end_of_message = last;
    in_valid <= 1;
    in_req <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_config(bit extreme);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      v = {$urandom, $urandom};
      if (extreme) v = ($urandom_range(0, 1) != 0) ? '1 : '0;
      write_reg(i[2:0], v);
    end
  endtask

  task automatic send_message(int len, bit gaps);
    logic [2:0] cnt;
    for (int i = 0; i < len; i++) begin
      cnt = 3'd4;
      if (i == len - 1 || $urandom_range(0, 19) == 0) cnt = 3'($urandom_range(0, 7));
      send_word($urandom, cnt, i == len - 1, gaps);
    end
  endtask

  initial begin
    int sent;
    int len;
    rst_n = 0;
    in_valid = 0;
    in_req = '0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_data = '0;
    out_hold = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(RegKey0, 64'h0706050403020100);
    write_reg(RegKey1, 64'h0f0e0d0c0b0a0908);
    write_reg(RegKey2, 64'h1716151413121110);
    write_reg(RegKey3, 64'h1f1e1d1c1b1a1918);
    write_reg(RegNonce0, 64'h4a00000000000000);
    write_reg(RegNonce1, 64'h0000000000000000);
    write_reg(RegStart, 64'd1);
    write_reg(RegUnused, '1);
    for (int c = 0; c < 8; c++) send_word(32'hFFFF_FFFF, c[2:0], 1'b0, 0);
    send_word(32'h0000_0000, 3'd4, 1'b0, 0);
    for (int i = 0; i < 9; i++) send_word($urandom, 3'd4, 1'b0, 0);
    drain();
    write_reg(RegKey0, '1);
    send_word(32'h1234_5678, 3'd4, 1'b0, 0);
    send_word(32'hA5A5_A5A5, 3'd2, 1'b1, 0);
    drain();
    write_reg(RegStart, 64'hFFFF_FFFF);
    send_message(20, 0);
    drain();
    out_hold = 0;

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      random_config(phase == 1 || phase == 3);
      if (phase == 2) write_reg(RegStart, 64'hFFFF_FFFE);
      for (int m = 0; m < 18; m++) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 18);
        send_message(len, $urandom_range(0, 3) != 0);
        sent += len;
        if (sent > 1820) break;
      end
      drain();
      if (sent > 1820) break;
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
